### rtl/core/pcs_pkg.sv
// Shared types and constants of the percentile color stretch block.
// No dependencies; pcs_front, pcs_back and the top level import this package.
`default_nettype none

package pcs_pkg;

	localparam int NCH      = 3;
	localparam int PIX_W    = 8;
	localparam int CLIP_W   = 14;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	// Rank divisor: percent in hundredths, split over two tails
	localparam logic [15:0] RANK_DIV = 16'd20000;

	// 2^37 / 625 rounded up: x * RECIP_625 >> RECIP_SH is floor(x / 625) for x below 2^27
	localparam logic [27:0] RECIP_625 = 28'd219902326;
	localparam int          RECIP_SH  = 37;

	typedef enum logic [1:0] {
		OP_COUNT  = 2'd0,
		OP_CLOSE  = 2'd1,
		OP_MAP    = 2'd2,
		OP_IGNORE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_BALANCE = 3'd0,
		REG_INVERT  = 3'd1,
		REG_CLIP_B  = 3'd2,
		REG_CLIP_G  = 3'd3,
		REG_CLIP_R  = 3'd4
	} reg_idx_t;

	// Channel order in all arrays: blue, green, red
	typedef struct packed {
		op_t                         op;
		logic [NCH-1:0][PIX_W-1:0]   pix;
	} item_t;

	typedef struct packed {
		logic   valid;
		item_t  item;
	} queue_head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

	typedef struct packed {
		logic                        balance;
		logic                        invert;
		logic [NCH-1:0][CLIP_W-1:0]  clip;
	} cfg_t;

	typedef struct packed {
		logic [NCH-1:0][PIX_W-1:0]   pix;
		logic [NCH-1:0][PIX_W-1:0]   low;
		logic [NCH-1:0][PIX_W-1:0]   high;
		logic                        is_report;
		logic                        frame_empty;
	} res_t;

endpackage

`default_nettype wire

### rtl/core/pcs_if.sv
// Stream channel interfaces: pixel/command input and result output.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface pcs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] in_blue;
	logic [7:0] in_green;
	logic [7:0] in_red;

	modport source (output valid, command, in_blue, in_green, in_red, input ready);
	modport sink (input valid, command, in_blue, in_green, in_red, output ready);
endinterface

interface pcs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic [7:0] low_blue;
	logic [7:0] low_green;
	logic [7:0] low_red;
	logic [7:0] high_blue;
	logic [7:0] high_green;
	logic [7:0] high_red;
	logic       is_report;
	logic       frame_empty;

	modport source (output valid, out_blue, out_green, out_red, low_blue, low_green,
		low_red, high_blue, high_green, high_red, is_report, frame_empty,
		input ready);
	modport sink (input valid, out_blue, out_green, out_red, low_blue, low_green,
		low_red, high_blue, high_green, high_red, is_report, frame_empty,
		output ready);
endinterface

`default_nettype wire

### rtl/core/pcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pcs_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/pcs_front.sv
// Front end: accepts input beats, drops unused commands, queues the rest.
// Depends on pcs_pkg and pcs_in_if.
`default_nettype none

module pcs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	pcs_in_if.sink               in_ch,
	input  pcs_pkg::back_ctl_t   ctl,
	output pcs_pkg::queue_head_t head
);
	import pcs_pkg::*;

	item_t      item_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       push;
	op_t        op_in;

	assign op_in       = op_t'(in_ch.command);
	assign in_ch.ready = (cnt_q != 2'd2) && !ctl.clearing;
	assign accept      = in_ch.valid && in_ch.ready;
	assign push        = accept && (op_in != OP_IGNORE);

	assign head.valid  = (cnt_q != 2'd0);
	assign head.item   = item_q[rd_ptr_q];

	// Two-entry queue between front and back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				item_q[wr_ptr_q] <= '{op: op_in,
					pix: {in_ch.in_red, in_ch.in_green, in_ch.in_blue}};
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (ctl.pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !ctl.pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && ctl.pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/pcs_back.sv
// Back end: histogram update, percentile walk on close, stretch on map,
// and the output register. Depends on pcs_pkg, pcs_if and pcs_ram.
`default_nettype none

module pcs_back #(
	parameter int COUNT_BITS = 21
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcs_pkg::cfg_t        cfg,
	input  pcs_pkg::queue_head_t head,
	output pcs_pkg::back_ctl_t   ctl,
	pcs_out_if.source            out_ch
);
	import pcs_pkg::*;

	localparam int CUM_W = COUNT_BITS + PIX_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CNT_WR, ST_CL_QUO, ST_CL_REM, ST_CL_MUL, ST_CL_DIV,
		ST_CL_RANK, ST_WALK, ST_MAP_PRE, ST_MAP_DIV, ST_MAP_FIN, ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [8:0]                      addr_q;
	logic                            rd_v_s1;
	logic [7:0]                      rd_addr_s1;
	logic [NCH-1:0][PIX_W-1:0]       px_q;
	logic [COUNT_BITS-1:0]           cnt_q;
	logic [COUNT_BITS-1:0]           n_q;
	logic [1:0]                      ch_q;
	logic [17:0]                     nq_q;
	logic [14:0]                     nr_q;
	logic [31:0]                     ac_q;
	logic [28:0]                     bc_q;
	logic [COUNT_BITS-1:0]           t_q;
	logic [NCH-1:0][COUNT_BITS-1:0]  lr_q;
	logic [NCH-1:0][COUNT_BITS-1:0]  hr_q;
	logic [NCH-1:0][CUM_W-1:0]       cum_q;
	logic [NCH-1:0]                  lo_found_q;
	logic [NCH-1:0]                  hi_found_q;
	logic [NCH-1:0][PIX_W-1:0]       low_q;
	logic [NCH-1:0][PIX_W-1:0]       high_q;
	logic [NCH-1:0][15:0]            mnum_q;
	logic [NCH-1:0][7:0]             md_q;
	logic [NCH-1:0][7:0]             mq_q;
	logic [NCH-1:0]                  mzero_q;
	logic [2:0]                      mbit_q;
	res_t                            res_q;
	res_t                            out_q;
	logic                            out_v_q;

	logic [NCH-1:0]                  h_we;
	logic [NCH-1:0][7:0]             h_waddr;
	logic [NCH-1:0][COUNT_BITS-1:0]  h_wdata;
	logic [NCH-1:0][7:0]             h_raddr;
	logic [NCH-1:0][COUNT_BITS-1:0]  h_rdata;

	logic [NCH-1:0][CUM_W-1:0]       cum_new;
	logic [NCH-1:0][15:0]            mtrial;
	logic [NCH-1:0]                  mtake;
	logic [NCH-1:0][PIX_W-1:0]       map_pix;
	logic [NCH-1:0][15:0]            pre_num;
	logic [54:0]                     nq_prod;
	logic [54:0]                     bq_prod;
	logic [32:0]                     nq_back;
	logic [COUNT_BITS-1:0]           nm1;
	logic [COUNT_BITS-1:0]           lr_full;
	logic [COUNT_BITS-1:0]           hr_full;
	logic                            slot_free;

	assign ctl.pop      = (state_q == ST_IDLE) && head.valid;
	assign ctl.clearing = (state_q == ST_CLEAR);
	assign slot_free    = !out_v_q || out_ch.ready;

	// Histogram memories, one per channel
	for (genvar c = 0; c < NCH; c++) begin : g_hist
		pcs_ram #(.WIDTH(COUNT_BITS), .DEPTH(256)) u_hist (
			.clk   (clk),
			.we    (h_we[c]),
			.waddr (h_waddr[c]),
			.wdata (h_wdata[c]),
			.raddr (h_raddr[c]),
			.rdata (h_rdata[c])
		);
	end

	// Memory port steering: clear sweep, count update, walk clear
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			h_raddr[c] = (state_q == ST_IDLE) ? head.item.pix[c] : addr_q[7:0];
			h_we[c]    = 1'b0;
			h_waddr[c] = addr_q[7:0];
			h_wdata[c] = '0;
			if (state_q == ST_CLEAR) begin
				h_we[c] = 1'b1;
			end else if (state_q == ST_CNT_WR) begin
				h_we[c]    = 1'b1;
				h_waddr[c] = px_q[c];
				h_wdata[c] = (h_rdata[c] == CNT_MAX) ? h_rdata[c]
					: h_rdata[c] + COUNT_BITS'(1);
			end else if ((state_q == ST_WALK) && rd_v_s1) begin
				h_we[c]    = 1'b1;
				h_waddr[c] = rd_addr_s1;
			end
		end
	end

	// Per-channel datapath: cumulative sums, stretch setup, divide step, rounding
	always_comb begin
		logic [PIX_W-1:0] v;
		logic [PIX_W-1:0] x;
		logic [8:0]       r2;
		logic             up;
		logic [8:0]       qq;
		logic [PIX_W-1:0] sv;
		for (int c = 0; c < NCH; c++) begin
			cum_new[c] = cum_q[c] + CUM_W'(h_rdata[c]);
			v = px_q[c];
			if (v < low_q[c]) v = low_q[c];
			if (v > high_q[c]) v = high_q[c];
			x = v - low_q[c];
			pre_num[c] = {x, 8'd0} - {8'd0, x};
			mtrial[c] = {8'd0, md_q[c]} << mbit_q;
			mtake[c]  = (mnum_q[c] >= mtrial[c]);
			r2 = {mnum_q[c][7:0], 1'b0};
			up = (r2 > {1'b0, md_q[c]}) || ((r2 == {1'b0, md_q[c]}) && mq_q[c][0]);
			qq = {1'b0, mq_q[c]} + {8'd0, up};
			if (qq[8]) qq = 9'd255;
			if (!cfg.balance) begin
				sv = px_q[c];
			end else if (mzero_q[c]) begin
				sv = '0;
			end else begin
				sv = qq[7:0];
			end
			map_pix[c] = cfg.invert ? ~sv : sv;
		end
	end

	// Rank arithmetic: n = 20000*q + r, so n*c/20000 = q*c + r*c/20000,
	// each division by 20000 a shift by five and a reciprocal multiply by 1/625
	assign nq_prod = 55'(27'(n_q >> 5)) * 55'(RECIP_625);
	assign nq_back = 33'(nq_q) * 33'(RANK_DIV);
	assign bq_prod = 55'(bc_q[28:5]) * 55'(RECIP_625);
	assign nm1     = n_q - COUNT_BITS'(1);
	assign lr_full = (t_q > nm1) ? nm1 : t_q;
	always_comb begin
		hr_full = (t_q <= n_q) ? n_q - t_q : '0;
		if (hr_full > nm1) hr_full = nm1;
	end

	// Sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			addr_q     <= '0;
			rd_v_s1    <= 1'b0;
			rd_addr_s1 <= '0;
			px_q       <= '0;
			cnt_q      <= '0;
			n_q        <= '0;
			ch_q       <= '0;
			nq_q       <= '0;
			nr_q       <= '0;
			ac_q       <= '0;
			bc_q       <= '0;
			t_q        <= '0;
			lr_q       <= '0;
			hr_q       <= '0;
			cum_q      <= '0;
			lo_found_q <= '0;
			hi_found_q <= '0;
			low_q      <= '0;
			high_q     <= '1;
			mnum_q     <= '0;
			md_q       <= '0;
			mq_q       <= '0;
			mzero_q    <= '0;
			mbit_q     <= '0;
			res_q      <= '0;
			out_q      <= '0;
			out_v_q    <= 1'b0;
		end else begin
			// Drop the taken result unless a new one loads this cycle
			if (out_v_q && out_ch.ready && (state_q != ST_EMIT)) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + 9'd1;
					if (addr_q[7:0] == 8'hFF) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						px_q <= head.item.pix;
						case (head.item.op)
							OP_COUNT: state_q <= ST_CNT_WR;
							OP_MAP:   state_q <= ST_MAP_PRE;
							OP_CLOSE: begin
								n_q   <= cnt_q;
								cnt_q <= '0;
								ch_q  <= '0;
								if (cnt_q == '0) begin
									low_q  <= '0;
									high_q <= '1;
									res_q  <= '{pix: '0, low: '0, high: '1,
										is_report: 1'b1, frame_empty: 1'b1};
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_CL_QUO;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CNT_WR: begin
					if (cnt_q != CNT_MAX) begin
						cnt_q <= cnt_q + COUNT_BITS'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_CL_QUO: begin
					nq_q    <= nq_prod[RECIP_SH +: 18];
					state_q <= ST_CL_REM;
				end
				ST_CL_REM: begin
					nr_q    <= 15'(33'(n_q) - nq_back);
					state_q <= ST_CL_MUL;
				end
				ST_CL_MUL: begin
					ac_q    <= 32'(nq_q) * 32'(cfg.clip[ch_q]);
					bc_q    <= 29'(nr_q) * 29'(cfg.clip[ch_q]);
					state_q <= ST_CL_DIV;
				end
				ST_CL_DIV: begin
					t_q     <= COUNT_BITS'(ac_q + 32'(bq_prod[RECIP_SH +: 18]));
					state_q <= ST_CL_RANK;
				end
				ST_CL_RANK: begin
					lr_q[ch_q] <= lr_full;
					hr_q[ch_q] <= hr_full;
					if (ch_q == 2'(NCH - 1)) begin
						addr_q     <= '0;
						rd_v_s1    <= 1'b0;
						cum_q      <= '0;
						lo_found_q <= '0;
						hi_found_q <= '0;
						low_q      <= '1;
						high_q     <= '1;
						state_q    <= ST_WALK;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= ST_CL_MUL;
					end
				end
				ST_WALK: begin
					// Issue one bin read per cycle, accumulate the previous one
					rd_v_s1    <= !addr_q[8];
					rd_addr_s1 <= addr_q[7:0];
					if (!addr_q[8]) begin
						addr_q <= addr_q + 9'd1;
					end
					if (rd_v_s1) begin
						for (int c = 0; c < NCH; c++) begin
							cum_q[c] <= cum_new[c];
							if (!lo_found_q[c] && (cum_new[c] > CUM_W'(lr_q[c]))) begin
								lo_found_q[c] <= 1'b1;
								low_q[c]      <= rd_addr_s1;
							end
							if (!hi_found_q[c] && (cum_new[c] > CUM_W'(hr_q[c]))) begin
								hi_found_q[c] <= 1'b1;
								high_q[c]     <= rd_addr_s1;
							end
						end
					end else if (addr_q[8]) begin
						res_q <= '{pix: '0, low: low_q, high: high_q,
							is_report: 1'b1, frame_empty: 1'b0};
						state_q <= ST_EMIT;
					end
				end
				ST_MAP_PRE: begin
					for (int c = 0; c < NCH; c++) begin
						mnum_q[c]  <= pre_num[c];
						md_q[c]    <= high_q[c] - low_q[c];
						mzero_q[c] <= (high_q[c] <= low_q[c]);
						mq_q[c]    <= '0;
					end
					mbit_q  <= 3'd7;
					state_q <= cfg.balance ? ST_MAP_DIV : ST_MAP_FIN;
				end
				ST_MAP_DIV: begin
					// One quotient bit per cycle for all channels
					for (int c = 0; c < NCH; c++) begin
						if (mtake[c]) begin
							mnum_q[c]         <= mnum_q[c] - mtrial[c];
							mq_q[c][mbit_q]   <= 1'b1;
						end
					end
					mbit_q <= mbit_q - 3'd1;
					if (mbit_q == 3'd0) begin
						state_q <= ST_MAP_FIN;
					end
				end
				ST_MAP_FIN: begin
					res_q <= '{pix: map_pix, low: low_q, high: high_q,
						is_report: 1'b0, frame_empty: 1'b0};
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_q   <= res_q;
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.out_blue    = out_q.pix[0];
	assign out_ch.out_green   = out_q.pix[1];
	assign out_ch.out_red     = out_q.pix[2];
	assign out_ch.low_blue    = out_q.low[0];
	assign out_ch.low_green   = out_q.low[1];
	assign out_ch.low_red     = out_q.low[2];
	assign out_ch.high_blue   = out_q.high[0];
	assign out_ch.high_green  = out_q.high[1];
	assign out_ch.high_red    = out_q.high[2];
	assign out_ch.is_report   = out_q.is_report;
	assign out_ch.frame_empty = out_q.frame_empty;

endmodule

`default_nettype wire

### rtl/core/percentile_color_stretch.sv
// Percentile color stretch. Count beats add a pixel to three 256-bin
// histograms; a close beat finds each channel's low and high percentile
// values, reports them and clears the histograms; map beats clip each
// channel to [low,high] and stretch it to 0..255 (rounded, ties to even)
// when balancing is on, optionally inverted. Steps per beat in the back
// end: count reads the histogram bin, then writes it back; map runs setup,
// an 8-step divider on all channels, rounding and the output load, with
// the divider skipped when balancing is off; close splits the pixel count
// by 20000 (quotient, then remainder), does the rank arithmetic per
// channel, then walks one bin per cycle over all 256 bins, clearing them
// as it goes, drains the read and loads the output, or goes straight to
// the output load on an empty frame. After reset a clearing pass zeroes
// the histograms; no input beat is taken during it. A two-entry queue and
// the output register let the input side keep accepting while a result
// waits. Depends on pcs_pkg, pcs_if, pcs_front and pcs_back.
`default_nettype none

module percentile_color_stretch #(
	parameter int COUNT_BITS = 21
) (
	input  logic                         clk,
	input  logic                         arst_n,
	pcs_in_if.sink                       in_ch,
	pcs_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pcs_pkg::PADDR_W-1:0]  paddr,
	input  logic [pcs_pkg::PDATA_W-1:0]  pwdata,
	output logic [pcs_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import pcs_pkg::*;

	cfg_t        cfg_q;
	queue_head_t head;
	back_ctl_t   ctl;
	reg_idx_t    reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.balance <= 1'b1;
			cfg_q.invert  <= 1'b0;
			cfg_q.clip    <= {NCH{CLIP_W'(100)}};
		end else if (wr_en) begin
			case (reg_idx)
				REG_BALANCE: cfg_q.balance <= pwdata[0];
				REG_INVERT:  cfg_q.invert  <= pwdata[0];
				REG_CLIP_B:  cfg_q.clip[0] <= pwdata[CLIP_W-1:0];
				REG_CLIP_G:  cfg_q.clip[1] <= pwdata[CLIP_W-1:0];
				REG_CLIP_R:  cfg_q.clip[2] <= pwdata[CLIP_W-1:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			REG_BALANCE: prdata = PDATA_W'(cfg_q.balance);
			REG_INVERT:  prdata = PDATA_W'(cfg_q.invert);
			REG_CLIP_B:  prdata = PDATA_W'(cfg_q.clip[0]);
			REG_CLIP_G:  prdata = PDATA_W'(cfg_q.clip[1]);
			REG_CLIP_R:  prdata = PDATA_W'(cfg_q.clip[2]);
			default:     prdata = '0;
		endcase
	end

	pcs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.ctl    (ctl),
		.head   (head)
	);

	pcs_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.ctl    (ctl),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

### rtl/core/pcs_checker.sv
// Port-level checks on the result channel of percentile_color_stretch.
// No package dependency; bound to the top level at the end of this file.
`default_nettype none

module pcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_blue,
	input logic [7:0] out_green,
	input logic [7:0] out_red,
	input logic [7:0] low_blue,
	input logic [7:0] low_green,
	input logic [7:0] low_red,
	input logic [7:0] high_blue,
	input logic [7:0] high_green,
	input logic [7:0] high_red,
	input logic       is_report,
	input logic       frame_empty
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Zero pixel fields in a report
	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_report |-> out_blue == 8'd0 && out_green == 8'd0
			&& out_red == 8'd0)
		else $error("report carries pixel data");

	// Empty frame reports full range
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_empty |-> is_report && low_blue == 8'd0
			&& low_green == 8'd0 && low_red == 8'd0 && high_blue == 8'd255
			&& high_green == 8'd255 && high_red == 8'd255)
		else $error("empty frame bounds wrong");

	// Bounds stay put between back-to-back mapped results
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !is_report ##1 out_valid && !is_report)
		|-> $stable(low_blue) && $stable(low_green) && $stable(low_red)
			&& $stable(high_blue) && $stable(high_green) && $stable(high_red))
		else $error("bounds changed without a report");

endmodule

bind percentile_color_stretch pcs_checker u_pcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_blue    (out_ch.out_blue),
	.out_green   (out_ch.out_green),
	.out_red     (out_ch.out_red),
	.low_blue    (out_ch.low_blue),
	.low_green   (out_ch.low_green),
	.low_red     (out_ch.low_red),
	.high_blue   (out_ch.high_blue),
	.high_green  (out_ch.high_green),
	.high_red    (out_ch.high_red),
	.is_report   (out_ch.is_report),
	.frame_empty (out_ch.frame_empty)
);

`default_nettype wire

### tb/sv/percentile_color_stretch_chk.sv
// Checker for the percentile color stretch block: it watches the input and result
// channels and the configuration port, predicts every result and compares it.
// Depends on pcs_pkg and the channel interfaces in pcs_if.
`timescale 1ns / 100ps

module percentile_color_stretch_chk
	import pcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	pcs_in_if                  in_ch,
	pcs_out_if                 out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 errors,
	output int                 pending
);

	localparam int COUNT_BITS = 21;
	localparam longint CNT_MAX = (longint'(1) << COUNT_BITS) - 1;

	// predicted block state; channel index 0 blue, 1 green, 2 red
	longint          hist [NCH][256];
	longint          pix_total;
	logic [7:0]      lo_val [NCH];
	logic [7:0]      hi_val [NCH];
	cfg_t            cfg;
	res_t            expected_res [$];

	assign pending = expected_res.size();

	// smallest bin whose running sum exceeds the rank
	function automatic logic [7:0] bin_at_rank(int ch, longint rank);
		longint sum;
		sum = 0;
		for (int v = 0; v < 256; v++) begin
			sum += hist[ch][v];
			if (sum > rank)
				return 8'(v);
		end
		return 8'd255;
	endfunction

	// clip to [lo,hi], scale to 0..255, round half to even
	function automatic logic [7:0] stretch_val(int v, int lo, int hi);
		int num, d, q, r;
		if (hi <= lo)
			return 8'd0;
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		num = (v - lo) * 255;
		d = hi - lo;
		q = num / d;
		r = num % d;
		if (2 * r > d || (2 * r == d && q[0]))
			q++;
		return (q > 255) ? 8'd255 : 8'(q);
	endfunction

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t   r;
		longint t, lr, hr;
		int     v;
		logic   empty;
		if (!arst_n) begin
			foreach (hist[c, b]) hist[c][b] = 0;
			pix_total = 0;
			foreach (lo_val[c]) begin
				lo_val[c] = 8'd0;
				hi_val[c] = 8'd255;
				cfg.clip[c] = CLIP_W'(100);
			end
			cfg.balance = 1'b1;
			cfg.invert = 1'b0;
			expected_res.delete();
			errors = 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0) begin
				case (paddr[4:2])
					REG_BALANCE: cfg.balance = pwdata[0];
					REG_INVERT:  cfg.invert = pwdata[0];
					REG_CLIP_B:  cfg.clip[0] = pwdata[CLIP_W-1:0];
					REG_CLIP_G:  cfg.clip[1] = pwdata[CLIP_W-1:0];
					REG_CLIP_R:  cfg.clip[2] = pwdata[CLIP_W-1:0];
					default: ;
				endcase
			end

			// compare a result beat with the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				if (expected_res.size() == 0) begin
					$error("result beat with no prediction waiting");
					errors++;
				end else begin
					r = expected_res.pop_front();
					check_field("out_blue", r.pix[0], out_ch.out_blue);
					check_field("out_green", r.pix[1], out_ch.out_green);
					check_field("out_red", r.pix[2], out_ch.out_red);
					check_field("low_blue", r.low[0], out_ch.low_blue);
					check_field("low_green", r.low[1], out_ch.low_green);
					check_field("low_red", r.low[2], out_ch.low_red);
					check_field("high_blue", r.high[0], out_ch.high_blue);
					check_field("high_green", r.high[1], out_ch.high_green);
					check_field("high_red", r.high[2], out_ch.high_red);
					check_field("is_report", r.is_report, out_ch.is_report);
					check_field("frame_empty", r.frame_empty, out_ch.frame_empty);
				end
			end

			// predict from an input beat
			if (in_ch.valid && in_ch.ready) begin
				r = '0;
				case (op_t'(in_ch.command))
					OP_COUNT: begin
						if (pix_total < CNT_MAX) pix_total++;
						if (hist[0][in_ch.in_blue] < CNT_MAX) hist[0][in_ch.in_blue]++;
						if (hist[1][in_ch.in_green] < CNT_MAX) hist[1][in_ch.in_green]++;
						if (hist[2][in_ch.in_red] < CNT_MAX) hist[2][in_ch.in_red]++;
					end
					OP_CLOSE: begin
						empty = (pix_total == 0);
						for (int c = 0; c < NCH; c++) begin
							if (empty) begin
								lo_val[c] = 8'd0;
								hi_val[c] = 8'd255;
							end else begin
								t = (pix_total * longint'(cfg.clip[c])) / 20000;
								lr = t;
								hr = (t <= pix_total) ? pix_total - t : 0;
								if (lr > pix_total - 1) lr = pix_total - 1;
								if (hr > pix_total - 1) hr = pix_total - 1;
								lo_val[c] = bin_at_rank(c, lr);
								hi_val[c] = bin_at_rank(c, hr);
							end
							r.low[c] = lo_val[c];
							r.high[c] = hi_val[c];
						end
						foreach (hist[c, b]) hist[c][b] = 0;
						pix_total = 0;
						r.is_report = 1'b1;
						r.frame_empty = empty;
						expected_res.insert(expected_res.size(), r);
					end
					OP_MAP: begin
						for (int c = 0; c < NCH; c++) begin
							v = (c == 0) ? in_ch.in_blue : (c == 1) ? in_ch.in_green
								: in_ch.in_red;
							if (cfg.balance) v = stretch_val(v, lo_val[c], hi_val[c]);
							if (cfg.invert) v = 255 - v;
							r.pix[c] = 8'(v);
							r.low[c] = lo_val[c];
							r.high[c] = hi_val[c];
						end
						expected_res.insert(expected_res.size(), r);
					end
					default: ;
				endcase
			end
		end
	end

endmodule

### tb/sv/percentile_color_stretch_tb.sv
// Top of the percentile color stretch testbench: clock, reset, stimulus,
// register phases and the verdict. Depends on pcs_pkg, pcs_if, the block
// and percentile_color_stretch_chk.
`timescale 1ns / 100ps

module percentile_color_stretch_tb;
	import pcs_pkg::*;

	localparam int SETTLE_CYCLES = 800;
	localparam int CYCLE_LIMIT   = 3000000;
	localparam int ITEM_TARGET   = 2000;

	typedef struct {
		logic        balance;
		logic        invert;
		int          clip_b;
		int          clip_g;
		int          clip_r;
	} cfg_set_t;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 errors, pending;
	int                 cycles;
	int                 items_sent;
	int                 stall_left;
	logic               idling_on;

	pcs_in_if  in_ch ();
	pcs_out_if out_ch ();

	percentile_color_stretch u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	percentile_color_stretch_chk u_chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[percentile_color_stretch] ERROR");
			$finish;
		end
	end

	// result side: random stall bursts while idling is on
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idling_on && $urandom_range(0, 9) == 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 18);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// one beat; hold valid until taken
	task automatic send(op_t op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
		if (idling_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= op;
		in_ch.in_blue <= b;
		in_ch.in_green <= g;
		in_ch.in_red <= r;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	// stop sending and wait for every predicted result to come back
	task automatic wait_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic reg_write(int idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_cfg(cfg_set_t s);
		// junk in the upper bits must be masked off
		reg_write(REG_BALANCE, 32'({$urandom(), s.balance}));
		reg_write(REG_INVERT, 32'({$urandom(), s.invert}));
		reg_write(REG_CLIP_B, 32'({$urandom(), 14'(s.clip_b)}));
		reg_write(REG_CLIP_G, 32'({$urandom(), 14'(s.clip_g)}));
		reg_write(REG_CLIP_R, 32'({$urandom(), 14'(s.clip_r)}));
	endtask

	// a frame: count beats, close, map beats, some noise
	task automatic random_frame();
		int         n_count, n_map, spread;
		logic [7:0] base_b, base_g, base_r;
		n_count = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 60);
		n_map = $urandom_range(1, 30);
		spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 255);
		base_b = 8'($urandom());
		base_g = 8'($urandom());
		base_r = 8'($urandom());
		for (int i = 0; i < n_count; i++) begin
			if ($urandom_range(0, 19) == 0)
				send(OP_IGNORE, 8'($urandom()), 8'($urandom()), 8'($urandom()));
			send(OP_COUNT, base_b + 8'($urandom_range(0, spread)),
				base_g + 8'($urandom_range(0, spread)),
				base_r + 8'($urandom_range(0, spread)));
		end
		send(OP_CLOSE, 8'($urandom()), 8'($urandom()), 8'($urandom()));
		for (int i = 0; i < n_map; i++)
			send(OP_MAP, 8'($urandom()), 8'($urandom()), 8'($urandom()));
	endtask

	initial begin
		cfg_set_t phases [6];
		phases[0] = '{1'b1, 1'b0, 100, 100, 100};
		phases[1] = '{1'b1, 1'b1, 0, 10000, 500};
		phases[2] = '{1'b0, 1'b0, 2000, 16383, 10001};
		phases[3] = '{1'b1, 1'b1, 1, 9999, 16383};
		phases[4] = '{1'b0, 1'b1, 5000, 0, 300};
		phases[5] = '{1'b1, 1'b0, 200, 10000, 0};

		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		items_sent = 0;
		stall_left = 0;
		idling_on = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.command = OP_COUNT;
		in_ch.in_blue = '0;
		in_ch.in_green = '0;
		in_ch.in_red = '0;
		out_ch.ready = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset bounds, empty frame, extremes, equal bounds
		send(OP_MAP, 8'd0, 8'd128, 8'd255);
		send(OP_CLOSE, 8'd0, 8'd0, 8'd0);
		send(OP_IGNORE, 8'hFF, 8'hFF, 8'hFF);
		send(OP_MAP, 8'd255, 8'd1, 8'd127);
		send(OP_COUNT, 8'd0, 8'd255, 8'd77);
		send(OP_COUNT, 8'd255, 8'd0, 8'd77);
		send(OP_COUNT, 8'd128, 8'd127, 8'd77);
		send(OP_COUNT, 8'd64, 8'd200, 8'd77);
		send(OP_CLOSE, 8'd0, 8'd0, 8'd0);
		send(OP_MAP, 8'd0, 8'd0, 8'd77);
		send(OP_MAP, 8'd255, 8'd255, 8'd76);
		send(OP_MAP, 8'd100, 8'd130, 8'd78);
		send(OP_MAP, 8'd170, 8'd85, 8'd0);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		// out-of-range register indexes are ignored
		reg_write(int'(REG_CLIP_R) + 1, 32'hFFFF_FFFF);
		reg_write(7, 32'h0000_0000);

		// random phases, each under its own register setting
		for (int p = 0; p < 6; p++) begin
			apply_cfg(phases[p]);
			idling_on = (p < 5) && ($urandom_range(0, 4) != 0);
			while (items_sent < (p + 1) * ITEM_TARGET / 6) begin
				random_frame();
				if ($urandom_range(0, 9) == 0)
					idling_on = (p < 5) && !idling_on;
				if ($urandom_range(0, 12) == 0)
					wait_results();
			end
			wait_results();
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		if (errors == 0)
			$display("[percentile_color_stretch] OK");
		else
			$display("[percentile_color_stretch] ERROR");
		$finish;
	end

endmodule

### files.f
rtl/core/pcs_pkg.sv
rtl/core/pcs_if.sv
rtl/core/pcs_ram.sv
rtl/core/pcs_front.sv
rtl/core/pcs_back.sv
rtl/core/percentile_color_stretch.sv
rtl/core/pcs_checker.sv
tb/sv/percentile_color_stretch_chk.sv
tb/sv/percentile_color_stretch_tb.sv
